// File: rtl/modular_exponentiation_defines.svh
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Clocked assertion, masked while in reset.
`define MEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form: whenever pre holds, con holds in the same cycle.
`define MEXP_ASSERT_IMPL(lbl, pre, con, msg) \
  `MEXP_ASSERT(lbl, (pre) |-> (con), msg)

`endif

// File: rtl/mexp_pkg.sv
package mexp_pkg;

  localparam int unsigned DATA_W        = 64;
  localparam int unsigned OPERAND_WIDTH = 64;
  localparam int unsigned CNT_W         = $clog2(OPERAND_WIDTH);

  typedef logic [OPERAND_WIDTH-1:0] opnd_t;
  typedef logic [CNT_W-1:0]         bit_cnt_t;

endpackage

// File: rtl/modular_exponentiation.sv
// Each modular multiply runs on the shared double-and-add unit.
// Zero modulus or zero exponent: result goes straight to the done state; one request in flight at a time.
// A new request is taken while the previous result waits in the output register.
// Reset (rst_ni low, async): sequencer idle, output register empty.
module modular_exponentiation (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // base_value [63:0], exponent_value [127:64], modulus_value [191:128]
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // power_result [63:0]
  output logic [63:0]  m_axis_tdata,
  // modulus_error [0]
  output logic         m_axis_tuser
);

  localparam int unsigned W  = mexp_pkg::OPERAND_WIDTH;
  localparam int unsigned DW = mexp_pkg::DATA_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_SQR  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]         state_q, state_d;
  mexp_pkg::opnd_t    base_q, base_d, exp_q, exp_d, mod_q, mod_d, acc_q, acc_d;
  mexp_pkg::bit_cnt_t cnt_q, cnt_d;
  logic               err_q, err_d;
  logic [DW-1:0]      res_q;
  logic               res_err_q, out_valid_q;

  mexp_pkg::opnd_t in_base, in_exp, in_mod, one_mod, mul_a, mul_b, mul_res;
  logic            mul_start, mul_done, out_load;

  assign in_base = s_axis_tdata[W-1:0];
  assign in_exp  = s_axis_tdata[DW+W-1:DW];
  assign in_mod  = s_axis_tdata[2*DW+W-1:2*DW];
  assign one_mod = (in_mod == W'(1)) ? '0 : W'(1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  mexp_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (mod_d),
    .res_o   (mul_res),
    .done_o  (mul_done)
  );

  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    exp_d     = exp_q;
    mod_d     = mod_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    mul_start = 1'b0;
    mul_a     = acc_q;
    mul_b     = acc_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          base_d = in_base;
          exp_d  = in_exp;
          mod_d  = in_mod;
          err_d  = 1'b0;
          if (in_mod == '0) begin
            acc_d   = '0;
            err_d   = 1'b1;
            state_d = ST_DONE;
          end else if (in_exp == '0) begin
            acc_d   = one_mod;
            state_d = ST_DONE;
          end else begin
            // base mod N as (1 mod N) * base
            mul_start = 1'b1;
            mul_a     = one_mod;
            mul_b     = in_base;
            state_d   = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mul_done) begin
          base_d  = mul_res;
          acc_d   = mul_res;
          cnt_d   = mexp_pkg::CNT_W'(W - 1);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        exp_d = {exp_q[W-2:0], 1'b0};
        if (!exp_q[W-1]) begin
          cnt_d = cnt_q - 1'b1;
        end else if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          mul_start = 1'b1;
          state_d   = ST_SQR;
        end
      end
      ST_SQR, ST_MUL: begin
        if (mul_done) begin
          acc_d = mul_res;
          if ((state_q == ST_SQR) && exp_q[W-1]) begin
            mul_start = 1'b1;
            mul_a     = mul_res;
            mul_b     = base_q;
            state_d   = ST_MUL;
          end else begin
            exp_d = {exp_q[W-2:0], 1'b0};
            cnt_d = cnt_q - 1'b1;
            if (cnt_q == mexp_pkg::CNT_W'(1)) begin
              state_d = ST_DONE;
            end else begin
              mul_start = 1'b1;
              mul_a     = mul_res;
              mul_b     = mul_res;
              state_d   = ST_SQR;
            end
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    mod_q  <= mod_d;
    acc_q  <= acc_d;
    cnt_q  <= cnt_d;
    err_q  <= err_d;
    if (out_load) begin
      res_q     <= DW'(acc_q);
      res_err_q <= err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = res_err_q;

endmodule

// File: rtl/mexp_mulmod.sv
`include "modular_exponentiation_defines.svh"

module mexp_mulmod (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mexp_pkg::opnd_t a_i,
  input  mexp_pkg::opnd_t b_i,
  input  mexp_pkg::opnd_t m_i,
  output mexp_pkg::opnd_t res_o,
  output logic            done_o
);

  localparam int unsigned W = mexp_pkg::OPERAND_WIDTH;

  mexp_pkg::opnd_t    acc_q, acc_d;
  mexp_pkg::opnd_t    a_q, b_q, m_q;
  mexp_pkg::bit_cnt_t cnt_q;
  logic               busy_q, done_q;

  logic [W:0]      dbl_sum, add_sum;
  mexp_pkg::opnd_t dbl_red, add_red;

  // One double-and-add step: acc = 2*acc + bit*a, both reduced mod m.
  always_comb begin
    dbl_sum = {acc_q, 1'b0};
    if (dbl_sum >= {1'b0, m_q}) begin
      dbl_red = W'(dbl_sum - {1'b0, m_q});
    end else begin
      dbl_red = dbl_sum[W-1:0];
    end
    add_sum = {1'b0, dbl_red} + {1'b0, a_q};
    if (add_sum >= {1'b0, m_q}) begin
      add_red = W'(add_sum - {1'b0, m_q});
    end else begin
      add_red = add_sum[W-1:0];
    end
    acc_d = b_q[W-1] ? add_red : dbl_red;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= mexp_pkg::CNT_W'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[W-2:0], 1'b0};
    end
  end

  assign res_o  = acc_q;
  assign done_o = done_q;

  `MEXP_ASSERT_IMPL(a_acc_below_mod, busy_q, acc_q < m_q, "accumulator left the residue range")
  `MEXP_ASSERT_IMPL(a_start_when_idle, start_i, !busy_q, "multiply started while busy")
  `MEXP_ASSERT(a_done_on_finish, $fell(busy_q) |-> done_q, "multiply ended without done")

endmodule
